[sv/bracket_balance_checker_unit_assert.svh]
// ----------------------------------------------------------------------------
// Bracket balance checker - assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BRACKET_BALANCE_CHECKER_UNIT_ASSERT_SVH
`define BRACKET_BALANCE_CHECKER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define BBC_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bracket checker: same-cycle check failed");

// Next-cycle implication.
`define BBC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bracket checker: next-cycle check failed");

`endif

[sv/bbc_pkg.sv]
// ----------------------------------------------------------------------------
// bbc_pkg
// Shared types and constants of the bracket balance checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bbc_pkg;

	localparam int STACK_DEPTH = 128;

	localparam logic [7:0] CHAR_OPEN_ROUND   = 8'h28; // (
	localparam logic [7:0] CHAR_CLOSE_ROUND  = 8'h29; // )
	localparam logic [7:0] CHAR_OPEN_SQUARE  = 8'h5B; // [
	localparam logic [7:0] CHAR_CLOSE_SQUARE = 8'h5D; // ]
	localparam logic [7:0] CHAR_OPEN_CURLY   = 8'h7B; // {
	localparam logic [7:0] CHAR_CLOSE_CURLY  = 8'h7D; // }

	typedef enum logic [1:0] {
		KIND_ROUND  = 2'd0,
		KIND_SQUARE = 2'd1,
		KIND_CURLY  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_MISMATCH = 2'd1,
		ERR_EMPTY    = 2'd2,
		ERR_OVERFLOW = 2'd3
	} err_t;

	// Front stage to resolve stage
	typedef struct packed {
		logic       pop;        // closer popped an entry; compare needed
		kind_t      kind;       // closer kind
		err_t       cand_err;   // overflow or empty found up front
		logic [7:0] depth;      // depth after this item, low bits
		logic       depth_zero; // full-width depth is zero
		logic       last;
	} front_t;

endpackage

[sv/bracket_balance_checker_unit.sv]
// ----------------------------------------------------------------------------
// bracket_balance_checker_unit
// Streaming bracket balance check over a bounded stack held in RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (char_valid/char_ready) takes one byte per item in character,
//   with last_char set on the final byte of an expression. Output channel
//   (result_valid/result_ready) returns one result per item: nesting_depth,
//   error_code (first error of the expression), expression_done and
//   is_balanced (no error and empty stack, only on the final byte).
//   Items pass the front stage register, then the output register. Throughput:
//   one item per cycle while result_ready is high. The stack count is updated
//   in the front stage per item; the popped entry comes from the registered
//   RAM port for the resolve stage compare, so at most one RAM access per item.
//   Reset clears the stack count, the error state and all valids; the RAM
//   needs no clearing since only entries pushed in the current expression
//   are read. After the final byte the count and error return to zero.
//   When result_ready is low the output register holds; one more item may
//   sit in the front stage, after which char_ready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bracket_balance_checker_unit #(
	parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       char_valid,
	output logic       char_ready,
	input  logic [7:0] character,
	input  logic       last_char,
	output logic       result_valid,
	input  logic       result_ready,
	output logic [7:0] nesting_depth,
	output logic [1:0] error_code,
	output logic       expression_done,
	output logic       is_balanced
);

	`include "bracket_balance_checker_unit_assert.svh"

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);

	logic [CW-1:0]   count_q;
	logic [CW-1:0]   count_dec;
	logic [CW-1:0]   count_after;
	logic            accept;
	logic            advance;
	logic            is_open;
	logic            is_close;
	bbc_pkg::kind_t  kind;
	logic            full;
	logic            empty;
	logic            push;
	logic            pop;

	logic            valid_s1;
	bbc_pkg::front_t front;
	bbc_pkg::front_t front_s1;
	logic [1:0]      rd_data;

	always_comb begin
		is_open  = 1'b0;
		is_close = 1'b0;
		kind     = bbc_pkg::KIND_ROUND;
		unique case (character)
			bbc_pkg::CHAR_OPEN_ROUND: begin
				is_open = 1'b1;
				kind    = bbc_pkg::KIND_ROUND;
			end
			bbc_pkg::CHAR_OPEN_SQUARE: begin
				is_open = 1'b1;
				kind    = bbc_pkg::KIND_SQUARE;
			end
			bbc_pkg::CHAR_OPEN_CURLY: begin
				is_open = 1'b1;
				kind    = bbc_pkg::KIND_CURLY;
			end
			bbc_pkg::CHAR_CLOSE_ROUND: begin
				is_close = 1'b1;
				kind     = bbc_pkg::KIND_ROUND;
			end
			bbc_pkg::CHAR_CLOSE_SQUARE: begin
				is_close = 1'b1;
				kind     = bbc_pkg::KIND_SQUARE;
			end
			bbc_pkg::CHAR_CLOSE_CURLY: begin
				is_close = 1'b1;
				kind     = bbc_pkg::KIND_CURLY;
			end
			default: begin
				is_open  = 1'b0;
				is_close = 1'b0;
			end
		endcase
	end

	assign char_ready = !valid_s1 || advance;
	assign accept     = char_valid && char_ready;

	assign full      = (count_q == CW'(STACK_DEPTH));
	assign empty     = (count_q == '0);
	assign count_dec = count_q - CW'(1);
	assign push      = accept && is_open && !full;
	assign pop       = accept && is_close && !empty;

	always_comb begin
		priority if (push) begin
			count_after = count_q + CW'(1);
		end else if (pop) begin
			count_after = count_dec;
		end else begin
			count_after = count_q;
		end
	end

	always_comb begin
		front.pop        = is_close && !empty;
		front.kind       = kind;
		if (is_open && full) begin
			front.cand_err = bbc_pkg::ERR_OVERFLOW;
		end else if (is_close && empty) begin
			front.cand_err = bbc_pkg::ERR_EMPTY;
		end else begin
			front.cand_err = bbc_pkg::ERR_NONE;
		end
		front.depth      = 8'(count_after);
		front.depth_zero = (count_after == '0);
		front.last       = last_char;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= last_char ? '0 : count_after;
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			front_s1 <= front;
		end
	end

	bbc_stack_ram #(
		.DEPTH (STACK_DEPTH),
		.AW    (AW)
	) u_stack_ram (
		.clk     (clk),
		.wr_en   (push),
		.wr_addr (count_q[AW-1:0]),
		.wr_data (kind),
		.rd_en   (pop),
		.rd_addr (count_dec[AW-1:0]),
		.rd_data (rd_data)
	);

	bbc_resolve u_resolve (
		.clk             (clk),
		.arst_n          (arst_n),
		.s1_valid        (valid_s1),
		.s1              (front_s1),
		.rd_data         (rd_data),
		.result_ready    (result_ready),
		.advance         (advance),
		.result_valid    (result_valid),
		.nesting_depth   (nesting_depth),
		.error_code      (error_code),
		.expression_done (expression_done),
		.is_balanced     (is_balanced)
	);

	`BBC_ASSERT_SAME(a_count_bounded, 1'b1, count_q <= CW'(STACK_DEPTH))
	`BBC_ASSERT_NEXT(a_count_clears_on_last, accept && last_char, count_q == '0)
	`BBC_ASSERT_SAME(a_stall_blocks_input, valid_s1 && result_valid && !result_ready, !char_ready)
	`BBC_ASSERT_SAME(a_balanced_consistent, result_valid && is_balanced,
		expression_done && (error_code == bbc_pkg::ERR_NONE) && (nesting_depth == 8'd0))

endmodule

[sv/bbc_stack_ram.sv]
// ----------------------------------------------------------------------------
// bbc_stack_ram
// Bracket stack storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bbc_stack_ram #(
	parameter int DEPTH = bbc_pkg::STACK_DEPTH,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [1:0]    wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [1:0]    rd_data
);

	logic [1:0] mem [DEPTH];
	logic [1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[sv/bbc_resolve.sv]
// ----------------------------------------------------------------------------
// bbc_resolve
// Kind compare against the popped entry, first-error tracking, output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bbc_resolve (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s1_valid,
	input  bbc_pkg::front_t  s1,
	input  logic [1:0]       rd_data,
	input  logic             result_ready,
	output logic             advance,
	output logic             result_valid,
	output logic [7:0]       nesting_depth,
	output logic [1:0]       error_code,
	output logic             expression_done,
	output logic             is_balanced
);

	bbc_pkg::err_t first_error_q;
	bbc_pkg::err_t item_err;
	bbc_pkg::err_t err_now;
	logic          mismatch;
	logic          move;

	logic          result_valid_q;
	logic [7:0]    depth_q;
	bbc_pkg::err_t err_q;
	logic          done_q;
	logic          balanced_q;

	assign advance  = !result_valid_q || result_ready;
	assign move     = s1_valid && advance;
	assign mismatch = s1.pop && (rd_data != s1.kind);

	always_comb begin
		if (s1.cand_err != bbc_pkg::ERR_NONE) begin
			item_err = s1.cand_err;
		end else if (mismatch) begin
			item_err = bbc_pkg::ERR_MISMATCH;
		end else begin
			item_err = bbc_pkg::ERR_NONE;
		end
		// only the first error of an expression sticks
		err_now = (first_error_q != bbc_pkg::ERR_NONE) ? first_error_q : item_err;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_error_q  <= bbc_pkg::ERR_NONE;
			result_valid_q <= 1'b0;
		end else begin
			if (move) begin
				first_error_q <= s1.last ? bbc_pkg::ERR_NONE : err_now;
			end
			if (advance) begin
				result_valid_q <= s1_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			depth_q    <= s1.depth;
			err_q      <= err_now;
			done_q     <= s1.last;
			balanced_q <= s1.last && (err_now == bbc_pkg::ERR_NONE) && s1.depth_zero;
		end
	end

	assign result_valid    = result_valid_q;
	assign nesting_depth   = depth_q;
	assign error_code      = err_q;
	assign expression_done = done_q;
	assign is_balanced     = balanced_q;

endmodule
